/* hdl/ptd3_pkg.sv */
// shared constants and types for the point to triangle distance block
package ptd3_pkg;

  // how the two weights are formed from the divider quotients
  typedef enum logic [2:0] {
    WS_FIXED,   // both weights come from the fixed fields
    WS_S_DIV,   // s is the lane 0 quotient
    WS_T_DIV,   // t is the lane 0 quotient
    WS_S_EDGE,  // s is the lane 0 quotient, t is one minus s
    WS_T_EDGE,  // t is the lane 0 quotient, s is one minus t
    WS_BOTH     // s from lane 0, t from lane 1
  } wsel_e;

endpackage

/* hdl/ptd3_if.sv */
// valid/ready channel carrying a payload of configurable type
interface ptd3_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/ptd3_div.sv */
// pipelined restoring fraction divider, one quotient bit per stage
module ptd3_div #(
  parameter int NumW  = 80,
  parameter int FracW = 16,
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [NumW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [FracW-1:0] quo_o,
  output logic [SideW-1:0] side_o
);
  // remainder kept below den so one extra bit suffices for the shift
  logic [NumW:0]      rem_q [FracW+1];
  logic [NumW-1:0]    den_q [FracW+1];
  logic [FracW-1:0]   quo_q [FracW+1];
  logic [SideW-1:0]   side_q [FracW+1];
  logic [FracW:0]     vld_q;

  always_comb begin
    rem_q[0]  = {1'b0, num_i};
    den_q[0]  = den_i;
    quo_q[0]  = '0;
    side_q[0] = side_i;
    vld_q[0]  = valid_i;
  end

  for (genvar g = 0; g < FracW; g++) begin : g_stage
    logic [NumW+1:0] sh;
    logic [NumW+1:0] df;
    logic [NumW:0]   rem_d;
    logic            bit_d;
    always_comb begin
      sh    = {rem_q[g], 1'b0};
      df    = sh - {2'b00, den_q[g]};
      bit_d = ~df[NumW+1];
      rem_d = bit_d ? df[NumW:0] : sh[NumW:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= rem_d;
        den_q[g+1]  <= den_q[g];
        quo_q[g+1]  <= {quo_q[g][FracW-2:0], bit_d};
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = vld_q[FracW];
  assign quo_o   = quo_q[FracW];
  assign side_o  = side_q[FracW];
endmodule

/* hdl/point_triangle_distance_3d_top.sv */
// top level: pipelined closest point and distance from a point to a triangle
//
//  channel  dir  payload
//  in_if    in   vertices a, b, c and query point, signed
//  out_if   out  distance, closest point, s, t, degenerate flag
//
// one transaction per cycle while the output is not stalled; the pipeline holds four
// front stages, an operand register, one divider stage per weight bit, three back
// stages and one square root stage per result bit.
// reset clears the valid bits of every stage; payload registers are not reset.
// the whole pipeline advances together and holds when the output is stalled.
module point_triangle_distance_3d_top #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptd3_if.sink   in_if,
  ptd3_if.source out_if
);
  import ptd3_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int EW  = CW + 1;            // edge vector
  localparam int DW  = 2 * EW + 2;        // dot products
  localparam int PW  = 2 * DW + 2;        // det, sn, tn
  localparam int NW  = PW + 2;            // divider numerator width
  localparam int SQW = 2 * EW + 3;        // squared distance
  localparam int RW  = (SQW + 1) / 2;     // its root
  localparam int OW  = F + 1;

  // ---------------------------------------------------------------------------
  // payload struct travelling through the divider
  typedef struct packed {
    logic signed [CW-1:0] ax, ay, az, px, py, pz;
    logic signed [EW-1:0] e0x, e0y, e0z, e1x, e1y, e1z;
    wsel_e                mode;   // how s and t come out of the quotients
    logic [F:0]           fs, ft; // fixed weights when no division
    logic                 degen;
    logic                 pair;   // interior: second divider lane used
  } side_t;
  localparam int SW = $bits(side_t);

  logic en;

  // stage 1: edges and offsets
  logic                 v1_q;
  logic signed [CW-1:0] a1_q [3], p1_q [3];
  logic signed [EW-1:0] e0_q [3], e1_q [3], dd_q [3];

  // stage 2: dot products
  logic                 v2_q;
  logic signed [CW-1:0] a2_q [3], p2_q [3];
  logic signed [EW-1:0] e02_q [3], e12_q [3];
  logic signed [DW-1:0] da_q, db_q, dc_q, dd2_q, de_q;

  // stage 3: products
  logic                 v3_q;
  logic signed [CW-1:0] a3_q [3], p3_q [3];
  logic signed [EW-1:0] e03_q [3], e13_q [3];
  logic signed [DW-1:0] a3d_q, b3_q, c3_q, d3_q, e3_q;
  logic signed [PW-1:0] ac_q, bb_q, be_q, cd_q, bd_q, ae_q;

  // stage 4: det, sn, tn
  logic                 v4_q;
  logic signed [CW-1:0] a4_q [3], p4_q [3];
  logic signed [EW-1:0] e04_q [3], e14_q [3];
  logic signed [DW-1:0] a4d_q, b4_q, c4_q, d4_q, e4_q;
  logic signed [PW-1:0] det_q, sn_q, tn_q;

  assign en          = out_if.ready || !out_if.valid;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_if.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // edges and a - p
  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q[0] <= in_if.data.vertex_a_x; a1_q[1] <= in_if.data.vertex_a_y;
      a1_q[2] <= in_if.data.vertex_a_z;
      p1_q[0] <= in_if.data.point_x; p1_q[1] <= in_if.data.point_y;
      p1_q[2] <= in_if.data.point_z;
      e0_q[0] <= EW'(in_if.data.vertex_b_x) - EW'(in_if.data.vertex_a_x);
      e0_q[1] <= EW'(in_if.data.vertex_b_y) - EW'(in_if.data.vertex_a_y);
      e0_q[2] <= EW'(in_if.data.vertex_b_z) - EW'(in_if.data.vertex_a_z);
      e1_q[0] <= EW'(in_if.data.vertex_c_x) - EW'(in_if.data.vertex_a_x);
      e1_q[1] <= EW'(in_if.data.vertex_c_y) - EW'(in_if.data.vertex_a_y);
      e1_q[2] <= EW'(in_if.data.vertex_c_z) - EW'(in_if.data.vertex_a_z);
      dd_q[0] <= EW'(in_if.data.vertex_a_x) - EW'(in_if.data.point_x);
      dd_q[1] <= EW'(in_if.data.vertex_a_y) - EW'(in_if.data.point_y);
      dd_q[2] <= EW'(in_if.data.vertex_a_z) - EW'(in_if.data.point_z);
    end
  end

  // dot products
  function automatic logic signed [DW-1:0] dot3(
    input logic signed [EW-1:0] x0, x1, x2, y0, y1, y2);
    logic signed [DW-1:0] r;
    r = DW'(x0 * y0) + DW'(x1 * y1) + DW'(x2 * y2);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= a1_q; p2_q <= p1_q; e02_q <= e0_q; e12_q <= e1_q;
      da_q  <= dot3(e0_q[0], e0_q[1], e0_q[2], e0_q[0], e0_q[1], e0_q[2]);
      db_q  <= dot3(e0_q[0], e0_q[1], e0_q[2], e1_q[0], e1_q[1], e1_q[2]);
      dc_q  <= dot3(e1_q[0], e1_q[1], e1_q[2], e1_q[0], e1_q[1], e1_q[2]);
      dd2_q <= dot3(e0_q[0], e0_q[1], e0_q[2], dd_q[0], dd_q[1], dd_q[2]);
      de_q  <= dot3(e1_q[0], e1_q[1], e1_q[2], dd_q[0], dd_q[1], dd_q[2]);
    end
  end

  // cross products of the dot terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= a2_q; p3_q <= p2_q; e03_q <= e02_q; e13_q <= e12_q;
      a3d_q <= da_q; b3_q <= db_q; c3_q <= dc_q; d3_q <= dd2_q; e3_q <= de_q;
      ac_q <= PW'(da_q) * PW'(dc_q);
      bb_q <= PW'(db_q) * PW'(db_q);
      be_q <= PW'(db_q) * PW'(de_q);
      cd_q <= PW'(dc_q) * PW'(dd2_q);
      bd_q <= PW'(db_q) * PW'(dd2_q);
      ae_q <= PW'(da_q) * PW'(de_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_q <= a3_q; p4_q <= p3_q; e04_q <= e03_q; e14_q <= e13_q;
      a4d_q <= a3d_q; b4_q <= b3_q; c4_q <= c3_q; d4_q <= d3_q; e4_q <= e3_q;
      det_q <= ac_q - bb_q;
      sn_q  <= be_q - cd_q;
      tn_q  <= bd_q - ae_q;
    end
  end

  // ---------------------------------------------------------------------------
  // region decision: picks divider inputs for up to two weights
  localparam logic [F:0] ONE = (F+1)'(1) << F;
  logic signed [NW-1:0] n0, d0, n1, d1;
  logic                 q0_zero, q0_one, q1_zero, q1_one;
  side_t                sd;

  always_comb begin
    logic signed [PW+1:0] ins;
    logic signed [DW+1:0] den, k0, k1, nm;
    ins = (PW+2)'(det_q) - (PW+2)'(sn_q) - (PW+2)'(tn_q);
    den = (DW+2)'(a4d_q) - ((DW+2)'(b4_q) <<< 1) + (DW+2)'(c4_q);
    k0  = '0; k1 = '0; nm = '0;
    n0 = '0; d0 = '0; n1 = '0; d1 = '0;
    sd.ax = a4_q[0]; sd.ay = a4_q[1]; sd.az = a4_q[2];
    sd.px = p4_q[0]; sd.py = p4_q[1]; sd.pz = p4_q[2];
    sd.e0x = e04_q[0]; sd.e0y = e04_q[1]; sd.e0z = e04_q[2];
    sd.e1x = e14_q[0]; sd.e1y = e14_q[1]; sd.e1z = e14_q[2];
    sd.mode = WS_FIXED; sd.fs = '0; sd.ft = '0;
    sd.degen = (det_q == '0); sd.pair = 1'b0;
    if (!sd.degen) begin
      if (!ins[PW+1]) begin
        if (sn_q[PW-1] && tn_q[PW-1]) begin
          if (d4_q[DW-1]) begin
            sd.mode = WS_S_DIV; n0 = -NW'(d4_q); d0 = NW'(a4d_q);
          end else if (e4_q[DW-1]) begin
            sd.mode = WS_T_DIV; n0 = -NW'(e4_q); d0 = NW'(c4_q);
          end
        end else if (sn_q[PW-1]) begin
          if (e4_q[DW-1]) begin
            sd.mode = WS_T_DIV; n0 = -NW'(e4_q); d0 = NW'(c4_q);
          end
        end else if (tn_q[PW-1]) begin
          if (d4_q[DW-1]) begin
            sd.mode = WS_S_DIV; n0 = -NW'(d4_q); d0 = NW'(a4d_q);
          end
        end else begin
          sd.mode = WS_BOTH; sd.pair = 1'b1;
          n0 = NW'(sn_q); d0 = NW'(det_q); n1 = NW'(tn_q); d1 = NW'(det_q);
        end
      end else if (sn_q[PW-1]) begin
        k0 = (DW+2)'(b4_q) + (DW+2)'(d4_q);
        k1 = (DW+2)'(c4_q) + (DW+2)'(e4_q);
        if (k1 > k0) begin
          sd.mode = WS_S_EDGE; n0 = NW'(k1 - k0); d0 = NW'(den);
        end else if (k1 <= 0) begin
          sd.ft = ONE;
        end else if (e4_q[DW-1]) begin
          sd.mode = WS_T_DIV; n0 = -NW'(e4_q); d0 = NW'(c4_q);
        end
      end else if (tn_q[PW-1]) begin
        k0 = (DW+2)'(b4_q) + (DW+2)'(e4_q);
        k1 = (DW+2)'(a4d_q) + (DW+2)'(d4_q);
        if (k1 > k0) begin
          sd.mode = WS_T_EDGE; n0 = NW'(k1 - k0); d0 = NW'(den);
        end else if (k1 <= 0) begin
          sd.fs = ONE;
        end else if (d4_q[DW-1]) begin
          sd.mode = WS_S_DIV; n0 = -NW'(d4_q); d0 = NW'(a4d_q);
        end
      end else begin
        nm = (DW+2)'(c4_q) + (DW+2)'(e4_q) - (DW+2)'(b4_q) - (DW+2)'(d4_q);
        if (nm <= 0) begin
          sd.ft = ONE;
        end else begin
          sd.mode = WS_S_EDGE; n0 = NW'(nm); d0 = NW'(den);
        end
      end
    end
    q0_zero = (n0 <= 0) || (d0 <= 0);
    q0_one  = !q0_zero && (n0 >= d0);
    q1_zero = (n1 <= 0) || (d1 <= 0);
    q1_one  = !q1_zero && (n1 >= d1);
  end

  // stage 5 registers division operands
  logic             v5_q;
  logic [NW-1:0]    n0_q, d0_q, n1_q, d1_q;
  side_t            sd5_q;
  logic [3:0]       fl5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_q <= (q0_zero || q0_one) ? '0 : n0; d0_q <= q0_zero ? NW'(1) : d0;
      n1_q <= (q1_zero || q1_one) ? '0 : n1; d1_q <= q1_zero ? NW'(1) : d1;
      sd5_q <= sd;
      fl5_q <= {q1_one, q1_zero, q0_one, q0_zero};
    end
  end

  // two divider lanes; lane 0 carries the side payload
  logic             vq0, vq1;
  logic [F-1:0]     qo0, qo1;
  logic [SW+3:0]    so0;
  logic [1:0]       so1;

  ptd3_div #(.NumW(NW), .FracW(F), .SideW(SW + 4)) u_div0 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .num_i(n0_q), .den_i(d0_q),
    .side_i({fl5_q, sd5_q}), .valid_o(vq0), .quo_o(qo0), .side_o(so0)
  );
  ptd3_div #(.NumW(NW), .FracW(F), .SideW(2)) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .num_i(n1_q), .den_i(d1_q),
    .side_i(fl5_q[3:2]), .valid_o(vq1), .quo_o(qo1), .side_o(so1)
  );

  // weights from quotients
  side_t      sd6;
  logic [F:0] w0, w1, s_w, t_w;
  always_comb begin
    sd6 = side_t'(so0[SW-1:0]);
    w0  = so0[SW+1] ? ONE : (so0[SW] ? '0 : {1'b0, qo0});
    w1  = so1[1] ? ONE : (so1[0] ? '0 : {1'b0, qo1});
    s_w = sd6.fs; t_w = sd6.ft;
    case (sd6.mode)
      WS_S_DIV:  s_w = w0;
      WS_T_DIV:  t_w = w0;
      WS_S_EDGE: begin s_w = w0; t_w = ONE - w0; end
      WS_T_EDGE: begin t_w = w0; s_w = ONE - w0; end
      WS_BOTH:   begin s_w = w0; t_w = w1; end
      default: ;
    endcase
  end

  // stage 6: weight times edge products
  localparam int MW = EW + F + 2;
  logic             v6_q;
  side_t            sd6_q;
  logic [F:0]       s6_q, t6_q;
  logic signed [MW-1:0] se_q [3], te_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= vq0 & vq1;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd6_q <= sd6; s6_q <= s_w; t6_q <= t_w;
      se_q[0] <= MW'($signed({1'b0, s_w})) * MW'(sd6.e0x);
      se_q[1] <= MW'($signed({1'b0, s_w})) * MW'(sd6.e0y);
      se_q[2] <= MW'($signed({1'b0, s_w})) * MW'(sd6.e0z);
      te_q[0] <= MW'($signed({1'b0, t_w})) * MW'(sd6.e1x);
      te_q[1] <= MW'($signed({1'b0, t_w})) * MW'(sd6.e1y);
      te_q[2] <= MW'($signed({1'b0, t_w})) * MW'(sd6.e1z);
    end
  end

  // stage 7: closest point and difference
  logic             v7_q;
  logic [F:0]       s7_q, t7_q;
  logic             dg7_q;
  logic signed [CW-1:0] q7_q [3];
  logic signed [EW-1:0] df7_q [3];
  logic signed [CW-1:0] av [3], pv [3];
  logic signed [MW-1:0] off [3];
  logic signed [CW-1:0] qv [3];
  always_comb begin
    av[0] = sd6_q.ax; av[1] = sd6_q.ay; av[2] = sd6_q.az;
    pv[0] = sd6_q.px; pv[1] = sd6_q.py; pv[2] = sd6_q.pz;
    for (int i = 0; i < 3; i++) begin
      off[i] = se_q[i] + te_q[i];
      qv[i]  = CW'(MW'(av[i]) + (off[i] >>> F));
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q <= s6_q; t7_q <= t6_q; dg7_q <= sd6_q.degen;
      for (int i = 0; i < 3; i++) begin
        q7_q[i]  <= qv[i];
        df7_q[i] <= EW'(qv[i]) - EW'(pv[i]);
      end
    end
  end

  // stage 8: squared distance
  logic             v8_q;
  logic [F:0]       s8_q, t8_q;
  logic             dg8_q;
  logic signed [CW-1:0] q8_q [3];
  logic [SQW-1:0]   sq8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q <= s7_q; t8_q <= t7_q; dg8_q <= dg7_q; q8_q <= q7_q;
      sq8_q <= SQW'(df7_q[0] * df7_q[0]) + SQW'(df7_q[1] * df7_q[1])
             + SQW'(df7_q[2] * df7_q[2]);
    end
  end

  // square root: one result bit per stage, operand padded to whole bit pairs
  logic [SQW+1:0]  rr_q [RW+1];
  logic [RW-1:0]   rt_q [RW+1];
  logic [2*RW-1:0] rv_q [RW+1];
  logic [RW:0]     rvld_q;
  logic [F:0]      rs_q [RW+1], rtt_q [RW+1];
  logic            rdg_q [RW+1];
  logic [3*CW-1:0] rq_q [RW+1];
  always_comb begin
    rr_q[0] = '0; rt_q[0] = '0; rv_q[0] = (2*RW)'(sq8_q); rvld_q[0] = v8_q;
    rs_q[0] = s8_q; rtt_q[0] = t8_q; rdg_q[0] = dg8_q;
    rq_q[0] = {q8_q[2], q8_q[1], q8_q[0]};
  end
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    logic [SQW+1:0] rem2, trial;
    logic           ok;
    always_comb begin
      rem2  = {rr_q[g][SQW-1:0], rv_q[g][2*RW-1 -: 2]};
      trial = (SQW+2)'({rt_q[g], 2'b01});
      ok    = rem2 >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rvld_q[g+1] <= 1'b0;
      else if (en) rvld_q[g+1] <= rvld_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rr_q[g+1]  <= ok ? rem2 - trial : rem2;
        rt_q[g+1]  <= {rt_q[g][RW-2:0], ok};
        rv_q[g+1]  <= {rv_q[g][2*RW-3:0], 2'b00};
        rs_q[g+1]  <= rs_q[g]; rtt_q[g+1] <= rtt_q[g];
        rdg_q[g+1] <= rdg_q[g]; rq_q[g+1] <= rq_q[g];
      end
    end
  end

  assign out_if.valid          = rvld_q[RW];
  assign out_if.data.distance  = (CW+1)'(rt_q[RW]);
  assign out_if.data.closest_x = rq_q[RW][CW-1:0];
  assign out_if.data.closest_y = rq_q[RW][2*CW-1:CW];
  assign out_if.data.closest_z = rq_q[RW][3*CW-1:2*CW];
  assign out_if.data.param_s   = rs_q[RW];
  assign out_if.data.param_t   = rtt_q[RW];
  assign out_if.data.degenerate = rdg_q[RW];
endmodule
